/* hw/rtl/gnfs_pkg.sv */
// Shared types, codes and constants for the greedy nearest free slot unit.
package gnfs_pkg;

    localparam int SLOT_W      = 4;
    localparam int COORD_W     = 14;
    localparam int TAG_W       = 10;
    localparam int STATUS_W    = 2;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int NUM_SLOTS_D = 9;

    localparam logic [STATUS_W-1:0] ST_ASSIGNED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WRITTEN  = 2'd2;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_ASSIGN = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [SLOT_W-1:0]  slot_select;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [TAG_W-1:0]   tag_number;
        logic               new_frame;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   chosen_slot;
        logic [TAG_W-1:0]    echo_tag;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic write_en;
        logic issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last_issue;
        logic pipe_busy;
    } stat_t;

endpackage

/* hw/rtl/greedy_nearest_free_slot_unit.sv */
// Top level of the greedy nearest free slot unit: controller plus datapath.
//
// This unit keeps a table of NUM_SLOTS slot positions, each with an occupied
// mark, and answers every input transaction with exactly one result
// transaction. A write transaction (mode 0) stores one slot's position in
// the write state and registers its result in the finish state; a write to
// a slot index beyond the table is dropped but still reported. An assign
// transaction (mode 1) optionally clears all occupied marks when its
// new-frame flag is set, then scans the slots one per cycle through a single
// distance unit (difference, square, then sum and compare, each registered)
// and picks the free slot nearest to the tag's centre by squared distance,
// the lowest index winning a tie. After the scan a drain step waits while
// free slots are still travelling through the distance pipeline, and the
// result is then registered in the finish state. The unit works on one
// transaction at a time and returns to idle, ready for the next one, when
// the result is registered. The result sits in an output register, so the
// next input transaction is accepted while the previous result still waits
// to be taken; a further result waits until that register is emptied. When
// no slot is free the result reports no free slot with slot zero.
// Coordinates are unsigned with four fractional bits; distances are exact.
module greedy_nearest_free_slot_unit #(
    parameter int NUM_SLOTS = gnfs_pkg::NUM_SLOTS_D
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gnfs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gnfs_pkg::out_item_t m_data
);

    // Commands from the controller and status back from the datapath.
    gnfs_pkg::cmd_t  cmd;
    gnfs_pkg::stat_t stat;

    // The controller sequences write, scan, drain and result hand-over, and
    // owns the result valid flag.
    gnfs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .item_mode (s_data.mode),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // The datapath holds the slot table, the occupied marks, the distance
    // pipeline, the running best candidate and the result register.
    gnfs_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

/* hw/rtl/gnfs_ctrl.sv */
// Controller state machine that sequences the write, scan and result steps.
module gnfs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           item_mode,
    output logic           m_valid,
    input  logic           m_ready,
    output gnfs_pkg::cmd_t cmd,
    input  gnfs_pkg::stat_t stat
);

    gnfs_pkg::state_t state_reg;
    gnfs_pkg::state_t state_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             out_free;

    // The result register can take a new result when empty or being emptied.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gnfs_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = (item_mode == gnfs_pkg::MODE_ASSIGN) ?
                                 gnfs_pkg::S_SCAN : gnfs_pkg::S_WRITE;
                end
            end
            gnfs_pkg::S_WRITE: begin
                state_next = gnfs_pkg::S_FINISH;
            end
            gnfs_pkg::S_SCAN: begin
                if (stat.last_issue) begin
                    state_next = gnfs_pkg::S_DRAIN;
                end
            end
            gnfs_pkg::S_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = gnfs_pkg::S_FINISH;
                end
            end
            gnfs_pkg::S_FINISH: begin
                if (out_free) begin
                    state_next = gnfs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = gnfs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            gnfs_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            gnfs_pkg::S_WRITE: begin
                cmd.write_en = 1'b1;
            end
            gnfs_pkg::S_SCAN: begin
                cmd.issue = 1'b1;
            end
            gnfs_pkg::S_DRAIN: begin
                cmd = '0;
            end
            gnfs_pkg::S_FINISH: begin
                cmd.finish = out_free;
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gnfs_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* hw/rtl/gnfs_datapath.sv */
// Datapath: slot table, occupied marks, distance pipeline and result register.
module gnfs_datapath #(
    parameter int NUM_SLOTS = gnfs_pkg::NUM_SLOTS_D
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gnfs_pkg::in_item_t  s_data,
    input  gnfs_pkg::cmd_t      cmd,
    output gnfs_pkg::stat_t     stat,
    output gnfs_pkg::out_item_t m_data
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    gnfs_pkg::in_item_t item_reg;

    logic [gnfs_pkg::COORD_W-1:0] pos_x_reg [NUM_SLOTS];
    logic [gnfs_pkg::COORD_W-1:0] pos_y_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]         taken_reg;
    logic [NUM_SLOTS-1:0]         taken_next;

    logic [IDX_W-1:0] idx_reg;

    // Stage 1: absolute coordinate differences.
    logic                         s1_valid_reg;
    logic [IDX_W-1:0]             s1_idx_reg;
    logic [gnfs_pkg::COORD_W-1:0] s1_dx_reg;
    logic [gnfs_pkg::COORD_W-1:0] s1_dy_reg;
    // Stage 2: squared differences.
    logic                         s2_valid_reg;
    logic [IDX_W-1:0]             s2_idx_reg;
    logic [gnfs_pkg::SQ_W-1:0]    s2_sqx_reg;
    logic [gnfs_pkg::SQ_W-1:0]    s2_sqy_reg;
    // Running best candidate.
    logic                         found_reg;
    logic [gnfs_pkg::DIST_W-1:0]  best_dist_reg;
    logic [IDX_W-1:0]             best_slot_reg;

    logic [gnfs_pkg::COORD_W-1:0] cur_x;
    logic [gnfs_pkg::COORD_W-1:0] cur_y;
    logic [gnfs_pkg::COORD_W-1:0] dx_next;
    logic [gnfs_pkg::COORD_W-1:0] dy_next;
    logic [gnfs_pkg::DIST_W-1:0]  dist_sum;
    logic                         better;
    logic                         sel_in_range;

    gnfs_pkg::out_item_t result_reg;
    gnfs_pkg::out_item_t result_next;

    assign cur_x   = pos_x_reg[idx_reg];
    assign cur_y   = pos_y_reg[idx_reg];
    assign dx_next = (item_reg.pos_x >= cur_x) ? (item_reg.pos_x - cur_x)
                                               : (cur_x - item_reg.pos_x);
    assign dy_next = (item_reg.pos_y >= cur_y) ? (item_reg.pos_y - cur_y)
                                               : (cur_y - item_reg.pos_y);

    assign dist_sum = {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};
    assign better   = s2_valid_reg && (!found_reg || (dist_sum < best_dist_reg));

    assign sel_in_range = ({1'b0, item_reg.slot_select} <
                           (gnfs_pkg::SLOT_W + 1)'(NUM_SLOTS));

    assign stat.last_issue = cmd.issue && (idx_reg == LAST_IDX);
    assign stat.pipe_busy  = s1_valid_reg || s2_valid_reg;

    always_comb begin
        taken_next = taken_reg;
        if (cmd.load && (s_data.mode == gnfs_pkg::MODE_ASSIGN) && s_data.new_frame) begin
            taken_next = '0;
        end
        if (cmd.finish && (item_reg.mode == gnfs_pkg::MODE_ASSIGN) && found_reg) begin
            taken_next[best_slot_reg] = 1'b1;
        end
    end

    always_comb begin
        result_next = result_reg;
        if (cmd.finish) begin
            if (item_reg.mode == gnfs_pkg::MODE_WRITE) begin
                result_next.status      = gnfs_pkg::ST_WRITTEN;
                result_next.chosen_slot = item_reg.slot_select;
                result_next.echo_tag    = '0;
            end else if (found_reg) begin
                result_next.status      = gnfs_pkg::ST_ASSIGNED;
                result_next.chosen_slot = gnfs_pkg::SLOT_W'(best_slot_reg);
                result_next.echo_tag    = item_reg.tag_number;
            end else begin
                result_next.status      = gnfs_pkg::ST_NO_FREE;
                result_next.chosen_slot = '0;
                result_next.echo_tag    = item_reg.tag_number;
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        s1_idx_reg <= idx_reg;
        s1_dx_reg  <= dx_next;
        s1_dy_reg  <= dy_next;
        s2_idx_reg <= s1_idx_reg;
        s2_sqx_reg <= gnfs_pkg::SQ_W'(s1_dx_reg) * gnfs_pkg::SQ_W'(s1_dx_reg);
        s2_sqy_reg <= gnfs_pkg::SQ_W'(s1_dy_reg) * gnfs_pkg::SQ_W'(s1_dy_reg);
        if (better) begin
            best_dist_reg <= dist_sum;
            best_slot_reg <= s2_idx_reg;
        end
        result_reg <= result_next;
    end

    // The slot table resets to the origin, so its entries are reset as well.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                pos_x_reg[i] <= '0;
                pos_y_reg[i] <= '0;
            end
            taken_reg    <= '0;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            if (cmd.write_en && sel_in_range) begin
                pos_x_reg[item_reg.slot_select[IDX_W-1:0]] <= item_reg.pos_x;
                pos_y_reg[item_reg.slot_select[IDX_W-1:0]] <= item_reg.pos_y;
            end
            taken_reg <= taken_next;
            if (cmd.load) begin
                idx_reg <= '0;
            end else if (cmd.issue && (idx_reg != LAST_IDX)) begin
                idx_reg <= idx_reg + 1'b1;
            end
            s1_valid_reg <= cmd.issue && !taken_reg[idx_reg];
            s2_valid_reg <= s1_valid_reg;
            if (cmd.load) begin
                found_reg <= 1'b0;
            end else if (better) begin
                found_reg <= 1'b1;
            end
        end
    end

    assign m_data = result_reg;

endmodule
